>>> rtl/core/chtag_pkg.sv
// Shared types and constants for the concat-heads tile address generator.
`default_nettype none

package chtag_pkg;

  localparam int DATA_W   = 32;
  localparam int ROWS_W   = 11;
  localparam int WIDTH_W  = 9;
  localparam int HEADS_W  = 9;
  localparam int PLANE_W  = 19;
  localparam int CHUNK_W  = 7;
  localparam int CFG_W    = 19;
  localparam int CFG_IDX_W = 3;

  localparam int ROW_POS_W   = 10;
  localparam int HEAD_POS_W  = 8;
  localparam int WIDTH_POS_W = 8;

  localparam int ROWS_MAX  = 1024;
  localparam int WIDTH_MAX = 256;
  localparam int HEADS_MAX = 256;
  localparam int PLANE_MAX = 262144;
  localparam int CHUNK_REG_MAX = (1 << CHUNK_W) - 1;

  // divider operand widths: divisor covers head_count * width_tiles
  localparam int DIVD_W = 32;
  localparam int DIVS_W = HEADS_W + WIDTH_W - 1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_TILES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK       = 3'd4;

  typedef enum logic [1:0] {
    DIV_SPLIT_ROWS,
    DIV_SPLIT_HEAD,
    DIV_SPLIT_BATCH
  } div_sel_t;

  typedef struct packed {
    logic     load_start;
    logic     mul_rows;
    logic     div_go;
    logic     div_take;
    div_sel_t div_sel;
    logic     step_mul1;
    logic     step_mul2;
    logic     step_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tiles_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/chtag_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module chtag_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [chtag_pkg::DIVD_W-1:0] dividend,
  input  wire logic [chtag_pkg::DIVS_W-1:0] divisor,
  output logic                             done,
  output logic [chtag_pkg::DIVD_W-1:0]     quot,
  output logic [chtag_pkg::DIVS_W-1:0]     rem
);
  import chtag_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]  trial;
  logic [DIVS_W:0]  diff;
  logic             ge;

  assign trial = {rem, quot[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quot <= {quot[DIVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/chtag_dp.sv
// Datapath: registers, position counters, page arithmetic, output register.
`default_nettype none

module chtag_dp #(
  parameter int MAX_CHUNK = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [chtag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [chtag_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [2*chtag_pkg::DATA_W-1:0] in_data,
  input  wire chtag_pkg::dp_cmd_t             cmd,
  output chtag_pkg::dp_status_t               status,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [chtag_pkg::DATA_W-1:0]        out_page,
  output logic                                out_chunk_last,
  output logic                                out_final
);
  import chtag_pkg::*;

  localparam int CHUNK_EFF = (MAX_CHUNK < CHUNK_REG_MAX) ? MAX_CHUNK : CHUNK_REG_MAX;
  localparam int CPOS_W    = (CHUNK_EFF > 1) ? $clog2(CHUNK_EFF) : 1;

  logic [ROWS_W-1:0]  rows;
  logic [WIDTH_W-1:0] wtiles;
  logic [HEADS_W-1:0] heads;
  logic [PLANE_W-1:0] plane;
  logic [CHUNK_W-1:0] chunk;

  logic [DATA_W-1:0]      batch_pos;
  logic [ROW_POS_W-1:0]   row_pos;
  logic [HEAD_POS_W-1:0]  head_pos;
  logic [WIDTH_POS_W-1:0] width_pos;
  logic [DATA_W-1:0]      tiles_left;
  logic [CPOS_W-1:0]      chunk_pos;

  logic [DATA_W-1:0] start_val;
  logic [DIVS_W-1:0] row_span;
  logic [DIVS_W-1:0] part_rem;

  logic [DATA_W-1:0]           p_bh;
  logic [HEAD_POS_W+PLANE_W-1:0] p_hp;
  logic [ROW_POS_W+WIDTH_W-1:0]  p_rw;
  logic [DATA_W-1:0]           p_bp;
  logic [HEAD_POS_W+PLANE_W:0] p_sum;

  logic [DATA_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic [DIVS_W-1:0] div_rem;

  logic [CHUNK_W:0]       cpos_inc;
  logic                   fin;
  logic                   clast;
  logic [WIDTH_POS_W:0]   width_inc;
  logic [HEAD_POS_W:0]    head_inc;
  logic [ROW_POS_W:0]     row_inc;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SPLIT_ROWS: begin
        div_dividend = start_val;
        div_divisor  = row_span;
      end
      DIV_SPLIT_HEAD: begin
        div_dividend = DATA_W'(part_rem);
        div_divisor  = DIVS_W'(wtiles);
      end
      DIV_SPLIT_BATCH: begin
        div_dividend = start_val;
        div_divisor  = DIVS_W'(rows);
      end
      default: begin
        div_dividend = start_val;
        div_divisor  = row_span;
      end
    endcase
  end

  chtag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign cpos_inc  = (CHUNK_W+1)'(chunk_pos) + 1'b1;
  assign fin       = (tiles_left == DATA_W'(1));
  assign clast     = fin || (cpos_inc >= {1'b0, chunk});
  assign width_inc = {1'b0, width_pos} + 1'b1;
  assign head_inc  = {1'b0, head_pos} + 1'b1;
  assign row_inc   = {1'b0, row_pos} + 1'b1;

  assign status.div_done   = div_done;
  assign status.tiles_zero = (tiles_left == '0);
  assign status.out_free   = !out_valid || out_ready;

  // config registers, values clamped into their legal range on write
  always_ff @(posedge clk) begin
    if (rst) begin
      rows   <= ROWS_W'(1);
      wtiles <= WIDTH_W'(1);
      heads  <= HEADS_W'(1);
      plane  <= PLANE_W'(1);
      chunk  <= CHUNK_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_TILES: begin
          if (cfg_data[ROWS_W-1:0] == '0) rows <= ROWS_W'(1);
          else if (cfg_data[ROWS_W-1:0] > ROWS_W'(ROWS_MAX)) rows <= ROWS_W'(ROWS_MAX);
          else rows <= cfg_data[ROWS_W-1:0];
        end
        REG_WIDTH_TILES: begin
          if (cfg_data[WIDTH_W-1:0] == '0) wtiles <= WIDTH_W'(1);
          else if (cfg_data[WIDTH_W-1:0] > WIDTH_W'(WIDTH_MAX)) wtiles <= WIDTH_W'(WIDTH_MAX);
          else wtiles <= cfg_data[WIDTH_W-1:0];
        end
        REG_HEAD_COUNT: begin
          if (cfg_data[HEADS_W-1:0] == '0) heads <= HEADS_W'(1);
          else if (cfg_data[HEADS_W-1:0] > HEADS_W'(HEADS_MAX)) heads <= HEADS_W'(HEADS_MAX);
          else heads <= cfg_data[HEADS_W-1:0];
        end
        REG_PLANE: begin
          if (cfg_data[PLANE_W-1:0] == '0) plane <= PLANE_W'(1);
          else if (cfg_data[PLANE_W-1:0] > PLANE_W'(PLANE_MAX)) plane <= PLANE_W'(PLANE_MAX);
          else plane <= cfg_data[PLANE_W-1:0];
        end
        REG_CHUNK: begin
          if (cfg_data[CHUNK_W-1:0] == '0) chunk <= CHUNK_W'(1);
          else if (32'(cfg_data[CHUNK_W-1:0]) > 32'(CHUNK_EFF)) chunk <= CHUNK_W'(CHUNK_EFF);
          else chunk <= cfg_data[CHUNK_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // position counters and tile budget
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pos  <= '0;
      row_pos    <= '0;
      head_pos   <= '0;
      width_pos  <= '0;
      tiles_left <= '0;
      chunk_pos  <= '0;
    end else if (cmd.load_start) begin
      tiles_left <= in_data[2*DATA_W-1:DATA_W];
      chunk_pos  <= '0;
    end else if (cmd.div_take) begin
      if (cmd.div_sel == DIV_SPLIT_HEAD) begin
        head_pos  <= div_quot[HEAD_POS_W-1:0];
        width_pos <= div_rem[WIDTH_POS_W-1:0];
      end else if (cmd.div_sel == DIV_SPLIT_BATCH) begin
        batch_pos <= div_quot;
        row_pos   <= div_rem[ROW_POS_W-1:0];
      end
    end else if (cmd.step_out) begin
      tiles_left <= tiles_left - 1'b1;
      chunk_pos  <= clast ? '0 : cpos_inc[CPOS_W-1:0];
      if (width_inc >= (WIDTH_POS_W+1)'(wtiles)) begin
        width_pos <= '0;
        if (head_inc >= (HEAD_POS_W+1)'(heads)) begin
          head_pos <= '0;
          if (row_inc >= (ROW_POS_W+1)'(rows)) begin
            row_pos   <= '0;
            batch_pos <= batch_pos + 1'b1;
          end else begin
            row_pos <= row_inc[ROW_POS_W-1:0];
          end
        end else begin
          head_pos <= head_inc[HEAD_POS_W-1:0];
        end
      end else begin
        width_pos <= width_inc[WIDTH_POS_W-1:0];
      end
    end
  end

  // start decode and page arithmetic operands
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      start_val <= in_data[DATA_W-1:0];
    end
    if (cmd.mul_rows) begin
      row_span <= DIVS_W'(heads) * DIVS_W'(wtiles);
    end
    if (cmd.div_take && cmd.div_sel == DIV_SPLIT_ROWS) begin
      start_val <= div_quot;
      part_rem  <= div_rem;
    end
    if (cmd.step_mul1) begin
      p_bh <= batch_pos * DATA_W'(heads);
      p_hp <= (HEAD_POS_W+PLANE_W)'(head_pos) * (HEAD_POS_W+PLANE_W)'(plane);
      p_rw <= (ROW_POS_W+WIDTH_W)'(row_pos) * (ROW_POS_W+WIDTH_W)'(wtiles);
    end
    if (cmd.step_mul2) begin
      p_bp  <= p_bh * DATA_W'(plane);
      p_sum <= (HEAD_POS_W+PLANE_W+1)'(p_hp) + (HEAD_POS_W+PLANE_W+1)'(p_rw)
             + (HEAD_POS_W+PLANE_W+1)'(width_pos);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_out) begin
      out_page       <= p_bp + DATA_W'(p_sum);
      out_chunk_last <= clast;
      out_final      <= fin;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/chtag_ctrl.sv
// Controller: sequences start decode divisions and step arithmetic.
`default_nettype none

module chtag_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_func,
  input  wire chtag_pkg::dp_status_t status,
  output chtag_pkg::dp_cmd_t        cmd
);
  import chtag_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_WAIT1,
    S_DIV2,
    S_WAIT2,
    S_DIV3,
    S_WAIT3,
    S_STEP1,
    S_STEP2,
    S_STEP3
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_SPLIT_ROWS;
    unique case (state)
      S_IDLE:  cmd.load_start = accept && (in_func == FUNC_START);
      S_MUL:   cmd.mul_rows = 1'b1;
      S_DIV1:  cmd.div_go = 1'b1;
      S_WAIT1: cmd.div_take = status.div_done;
      S_DIV2: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_SPLIT_HEAD;
      end
      S_WAIT2: begin
        cmd.div_take = status.div_done;
        cmd.div_sel  = DIV_SPLIT_HEAD;
      end
      S_DIV3: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_SPLIT_BATCH;
      end
      S_WAIT3: begin
        cmd.div_take = status.div_done;
        cmd.div_sel  = DIV_SPLIT_BATCH;
      end
      S_STEP1: cmd.step_mul1 = 1'b1;
      S_STEP2: cmd.step_mul2 = 1'b1;
      S_STEP3: cmd.step_out  = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_func == FUNC_START) state <= S_MUL;
            else if (!status.tiles_zero) state <= S_STEP1;
          end
        end
        S_MUL:   state <= S_DIV1;
        S_DIV1:  state <= S_WAIT1;
        S_WAIT1: if (status.div_done) state <= S_DIV2;
        S_DIV2:  state <= S_WAIT2;
        S_WAIT2: if (status.div_done) state <= S_DIV3;
        S_DIV3:  state <= S_WAIT3;
        S_WAIT3: if (status.div_done) state <= S_IDLE;
        S_STEP1: state <= S_STEP2;
        S_STEP2: state <= S_STEP3;
        S_STEP3: if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/concat_heads_tile_address_generator_unit.sv
// Top level of the concat-heads tile address generator.
//
//  channel  | signals                              | contents
//  s_axis   | tvalid tready tdata[63:0] tuser      | first_tile, tile_count; tuser func
//  m_axis   | tvalid tready tdata[31:0] tlast tuser | page_index; tlast chunk_last; tuser final_tile
//  cfg      | cfg_write cfg_index cfg_data         | register write, no read-back
//
// A step item passes through accept, two multiply stages, then the output register load.
// A start item passes through accept, one multiply, then three divisions
// (launch, 32 quotient bits, result take) through the single shared divider.
// A step with no tiles left is absorbed in its accept cycle.
// Input is taken while a result waits; the output register stall holds only the output register load.
// Reset is synchronous and returns the registers to 1 and the counters to zero.
`default_nettype none

module concat_heads_tile_address_generator_unit #(
  parameter int MAX_CHUNK = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [chtag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [chtag_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [2*chtag_pkg::DATA_W-1:0]   s_axis_tdata,  // first_tile, tile_count
  input  wire logic                             s_axis_tuser,  // func
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [chtag_pkg::DATA_W-1:0]          m_axis_tdata,  // page_index
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tuser   // final_tile
);
  import chtag_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  chtag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  chtag_dp #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_data        (s_axis_tdata),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_page       (m_axis_tdata),
    .out_chunk_last (m_axis_tlast),
    .out_final      (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/core/chtag_checker.sv
// Port-level assertions for the concat-heads tile address generator.
`default_nettype none

module chtag_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [chtag_pkg::DATA_W-1:0]     m_axis_tdata,
  input wire logic                             m_axis_tlast,
  input wire logic                             m_axis_tuser
);
  import chtag_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_final_closes_chunk: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("final tile not flagged as chunk end");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_START) |=> !s_axis_tready)
    else $error("input taken during start decode");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("result or busy state after reset");

endmodule

bind concat_heads_tile_address_generator_unit chtag_checker u_chtag_checker (.*);

`default_nettype wire
